### rtl/btpl_pkg.sv
// Package for the binary trie prefix lookup block: transfer payload types,
// operation codes, sequencer states and fixed field widths.
// Depends on nothing; every other file of the block but btpl_ram imports it.
package btpl_pkg;

    // Fixed field widths of the request and response items.
    localparam int ADDR_W = 32;
    localparam int HOP_W = 32;
    localparam int PORT_W = 8;
    localparam int OP_W = 2;

    // Width of the level counter, which runs from ADDR_W down to zero.
    localparam int LVL_W = $clog2(ADDR_W + 1);

    // Default size of the node pool, root included.
    localparam int NODE_COUNT_DEF = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_ALLOC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] prefix_mask;
        logic [HOP_W-1:0]  hop_in;
        logic [PORT_W-1:0] port_in;
    } req_item_t;

    typedef struct packed {
        logic              found;
        logic [HOP_W-1:0]  hop_out;
        logic [PORT_W-1:0] port_out;
        logic              pool_full;
    } rsp_item_t;

endpackage

### rtl/binary_trie_prefix_lookup.sv
// An insert or lookup walks the trie one level per node memory read, and an
// insert adds an allocation step for every node it creates; clear and unused
// codes go straight to the response state.
// One item at a time: a new request is taken the cycle after the result is
// handed to the output register; the single node memory port, read once per
// level, sets the walk length. Reset clears root and allocator.
// Top level of the IPv4 longest-prefix-match trie.
// Depends on btpl_pkg, btpl_ram, btpl_walk and btpl_result.
module binary_trie_prefix_lookup #(
    parameter int NODE_COUNT = btpl_pkg::NODE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  btpl_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output btpl_pkg::rsp_item_t rsp
);

    import btpl_pkg::*;

    // Each node holds two child indices, a valid bit, a next hop and a port.
    // Index zero means "no child", which is safe because the root is never a
    // child. The root itself lives in flip-flops inside the sequencer, so a
    // reset or a clear empties the table at once without a clearing pass;
    // memory entry zero is never used. Every other entry is written empty
    // when it is allocated, so no undefined entry is ever read.
    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int NODE_W = 2 * IDX_W + 1 + HOP_W + PORT_W;

    logic              ram_rd_en;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_addr;
    logic [NODE_W-1:0] ram_wdata;
    logic [NODE_W-1:0] ram_rdata;

    // Finished results move from the sequencer to the output register by a
    // local valid and ready transfer.
    logic              push_valid;
    logic              push_ready;
    rsp_item_t         push_data;

    btpl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .rd_en (ram_rd_en),
        .wr_en (ram_wr_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // The sequencer issues one node read per level and uses the registered
    // read data in the next cycle to pick the following child. Reads and
    // writes never share a cycle, and a walk never returns to a node it has
    // just written, so no forwarding path is needed.
    btpl_walk #(
        .NODE_COUNT (NODE_COUNT)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .ram_rd_en  (ram_rd_en),
        .ram_wr_en  (ram_wr_en),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata)
    );

    btpl_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

### rtl/btpl_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Self-contained; used for the trie node memory.
module btpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/btpl_walk.sv
// Trie walk sequencer: root node and allocator in flip-flops; walks the node
// memory one level per cycle outside allocation steps. Depends on btpl_pkg.
module btpl_walk #(
    parameter int NODE_COUNT = btpl_pkg::NODE_COUNT_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              req_valid,
    output logic                                              req_ready,
    input  btpl_pkg::req_item_t                               req,
    output logic                                              push_valid,
    input  logic                                              push_ready,
    output btpl_pkg::rsp_item_t                               push_data,
    output logic                                              ram_rd_en,
    output logic                                              ram_wr_en,
    output logic [$clog2(NODE_COUNT)-1:0]                     ram_addr,
    output logic [2*$clog2(NODE_COUNT)+btpl_pkg::HOP_W+btpl_pkg::PORT_W:0] ram_wdata,
    input  logic [2*$clog2(NODE_COUNT)+btpl_pkg::HOP_W+btpl_pkg::PORT_W:0] ram_rdata
);

    import btpl_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic [IDX_W-1:0]  kid1;
        logic [IDX_W-1:0]  kid0;
        logic              valid;
        logic [HOP_W-1:0]  hop;
        logic [PORT_W-1:0] port;
    } node_t;

    state_t            state_reg, state_next;
    node_t             root_reg, root_next;
    logic [CNT_W-1:0]  next_free_reg, next_free_next;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] mask_reg, mask_next;
    logic [HOP_W-1:0]  hop_reg, hop_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  alloc_reg, alloc_next;
    logic              from_ram_reg, from_ram_next;
    node_t             node_reg, node_next;
    logic              found_reg, found_next;
    logic [HOP_W-1:0]  best_hop_reg, best_hop_next;
    logic [PORT_W-1:0] best_port_reg, best_port_next;
    logic              pool_full_reg, pool_full_next;

    node_t             cur_data;
    node_t             upd_node;
    logic              bit_b;
    logic [IDX_W-1:0]  nxt_idx;
    logic              walk_done;

    // The current node comes from the memory read issued last cycle, or from
    // the local copy (root, or a node that was just created empty).
    assign cur_data  = from_ram_reg ? node_t'(ram_rdata) : node_reg;
    assign bit_b     = addr_reg[ADDR_W-1];
    assign nxt_idx   = bit_b ? cur_data.kid1 : cur_data.kid0;
    assign walk_done = (lvl_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            root_reg      <= '0;
            next_free_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            next_free_reg <= next_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        mask_reg      <= mask_next;
        hop_reg       <= hop_next;
        port_reg      <= port_next;
        lvl_reg       <= lvl_next;
        cur_reg       <= cur_next;
        alloc_reg     <= alloc_next;
        from_ram_reg  <= from_ram_next;
        node_reg      <= node_next;
        found_reg     <= found_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        pool_full_reg <= pool_full_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        root_next      = root_reg;
        next_free_next = next_free_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        mask_next      = mask_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        lvl_next       = lvl_reg;
        cur_next       = cur_reg;
        alloc_next     = alloc_reg;
        from_ram_next  = from_ram_reg;
        node_next      = node_reg;
        found_next     = found_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        pool_full_next = pool_full_reg;

        req_ready  = 1'b0;
        push_valid = 1'b0;
        ram_rd_en  = 1'b0;
        ram_wr_en  = 1'b0;
        ram_addr   = cur_reg;
        ram_wdata  = '0;

        upd_node = cur_data;
        if (bit_b)
        begin
            upd_node.kid1 = next_free_reg[IDX_W-1:0];
        end
        else
        begin
            upd_node.kid0 = next_free_reg[IDX_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next        = req.op;
                    addr_next      = req.address;
                    mask_next      = req.prefix_mask;
                    hop_next       = req.hop_in;
                    port_next      = req.port_in;
                    lvl_next       = LVL_W'(ADDR_W);
                    cur_next       = '0;
                    from_ram_next  = 1'b0;
                    node_next      = root_reg;
                    found_next     = 1'b0;
                    best_hop_next  = '0;
                    best_port_next = '0;
                    pool_full_next = 1'b0;
                    case (req.op)
                        OP_INSERT,
                        OP_LOOKUP:
                        begin
                            state_next = ST_STEP;
                        end
                        OP_CLEAR:
                        begin
                            root_next      = '0;
                            next_free_next = CNT_W'(1);
                            state_next     = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_STEP:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (walk_done || !mask_reg[ADDR_W-1])
                        begin
                            upd_node       = cur_data;
                            upd_node.valid = 1'b1;
                            upd_node.hop   = hop_reg;
                            upd_node.port  = port_reg;
                            if (cur_reg == '0)
                            begin
                                root_next = upd_node;
                            end
                            else
                            begin
                                ram_wr_en = 1'b1;
                                ram_wdata = upd_node;
                            end
                            state_next = ST_RESP;
                        end
                        else if (nxt_idx != '0)
                        begin
                            ram_rd_en     = 1'b1;
                            ram_addr      = nxt_idx;
                            cur_next      = nxt_idx;
                            from_ram_next = 1'b1;
                            addr_next     = {addr_reg[ADDR_W-2:0], 1'b0};
                            mask_next     = {mask_reg[ADDR_W-2:0], 1'b0};
                            lvl_next      = lvl_reg - LVL_W'(1);
                        end
                        else if (next_free_reg >= CNT_W'(NODE_COUNT))
                        begin
                            pool_full_next = 1'b1;
                            state_next     = ST_RESP;
                        end
                        else
                        begin
                            // Link the new child into the current node now;
                            // the child itself is written empty next cycle.
                            if (cur_reg == '0)
                            begin
                                root_next = upd_node;
                            end
                            else
                            begin
                                ram_wr_en = 1'b1;
                                ram_wdata = upd_node;
                            end
                            alloc_next     = next_free_reg[IDX_W-1:0];
                            next_free_next = next_free_reg + CNT_W'(1);
                            state_next     = ST_ALLOC;
                        end
                    end

                    OP_LOOKUP:
                    begin
                        if (cur_data.valid)
                        begin
                            found_next     = 1'b1;
                            best_hop_next  = cur_data.hop;
                            best_port_next = cur_data.port;
                        end
                        if (walk_done || (nxt_idx == '0))
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            ram_rd_en     = 1'b1;
                            ram_addr      = nxt_idx;
                            cur_next      = nxt_idx;
                            from_ram_next = 1'b1;
                            addr_next     = {addr_reg[ADDR_W-2:0], 1'b0};
                            lvl_next      = lvl_reg - LVL_W'(1);
                        end
                    end

                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_ALLOC:
            begin
                ram_wr_en     = 1'b1;
                ram_addr      = alloc_reg;
                ram_wdata     = '0;
                cur_next      = alloc_reg;
                node_next     = '0;
                from_ram_next = 1'b0;
                addr_next     = {addr_reg[ADDR_W-2:0], 1'b0};
                mask_next     = {mask_reg[ADDR_W-2:0], 1'b0};
                lvl_next      = lvl_reg - LVL_W'(1);
                state_next    = ST_STEP;
            end

            ST_RESP:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign push_data = '{
        found:     found_reg,
        hop_out:   best_hop_reg,
        port_out:  best_port_reg,
        pool_full: pool_full_reg
    };

endmodule

### rtl/btpl_result.sv
// Response output register: holds one finished result until it is taken,
// so the sequencer can start the next item meanwhile. Depends on btpl_pkg.
module btpl_result (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  btpl_pkg::rsp_item_t push_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output btpl_pkg::rsp_item_t rsp
);

    import btpl_pkg::*;

    logic      valid_reg, valid_next;
    rsp_item_t data_reg;

    assign push_ready = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_valid && push_ready)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            data_reg <= push_data;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

### tb/lpm_route_checker.sv
`timescale 1ns / 100ps
// Checker for the binary trie prefix lookup: keeps its own copy of the route trie
// and compares every response transfer with the expected result.
// Depends on btpl_pkg for the payload types and operation codes.
module lpm_route_checker #(
    parameter int NODE_COUNT = btpl_pkg::NODE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  btpl_pkg::req_item_t req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  btpl_pkg::rsp_item_t rsp,
    output int                  mismatches,
    output int                  outstanding,
    output int                  lookup_hits,
    output int                  dropped_inserts
);
    import btpl_pkg::*;

    // Shadow trie: a child index of zero means no child, as the root is never one.
    int unsigned       child_zero [NODE_COUNT];
    int unsigned       child_one  [NODE_COUNT];
    logic              entry_valid [NODE_COUNT];
    logic [HOP_W-1:0]  entry_hop  [NODE_COUNT];
    logic [PORT_W-1:0] entry_port [NODE_COUNT];
    int unsigned       free_slot;

    rsp_item_t expected_routes [$];

    function automatic void empty_node(int unsigned idx);
        child_zero[idx] = 0;
        child_one[idx] = 0;
        entry_valid[idx] = 1'b0;
        entry_hop[idx] = '0;
        entry_port[idx] = '0;
    endfunction

    // Applies one request to the shadow trie and returns the response it should get.
    function automatic rsp_item_t apply_route_op(req_item_t item);
        rsp_item_t   res;
        int unsigned cur;
        int unsigned nxt;
        int          pos;
        logic        walking;
        res = '0;
        cur = 0;
        pos = ADDR_W - 1;
        walking = 1'b1;
        case (item.op)
            OP_INSERT:
            begin
                // One level per leading one of the mask; bits after the first zero do not count.
                while (walking && pos >= 0 && item.prefix_mask[pos])
                begin
                    nxt = item.address[pos] ? child_one[cur] : child_zero[cur];
                    if (nxt == 0)
                    begin
                        if (free_slot >= NODE_COUNT)
                        begin
                            // Pool exhausted: nodes made earlier on this walk stay behind.
                            res.pool_full = 1'b1;
                            walking = 1'b0;
                        end
                        else
                        begin
                            nxt = free_slot;
                            free_slot++;
                            empty_node(nxt);
                            if (item.address[pos])
                                child_one[cur] = nxt;
                            else
                                child_zero[cur] = nxt;
                        end
                    end
                    if (walking)
                    begin
                        cur = nxt;
                        pos--;
                    end
                end
                if (!res.pool_full)
                begin
                    entry_valid[cur] = 1'b1;
                    entry_hop[cur] = item.hop_in;
                    entry_port[cur] = item.port_in;
                end
            end
            OP_LOOKUP:
            begin
                // The root holds the default route and is checked before the walk.
                if (entry_valid[0])
                begin
                    res.found = 1'b1;
                    res.hop_out = entry_hop[0];
                    res.port_out = entry_port[0];
                end
                while (walking && pos >= 0)
                begin
                    nxt = item.address[pos] ? child_one[cur] : child_zero[cur];
                    if (nxt == 0)
                        walking = 1'b0;
                    else
                    begin
                        cur = nxt;
                        if (entry_valid[cur])
                        begin
                            res.found = 1'b1;
                            res.hop_out = entry_hop[cur];
                            res.port_out = entry_port[cur];
                        end
                        pos--;
                    end
                end
            end
            OP_CLEAR:
            begin
                empty_node(0);
                free_slot = 1;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        rsp_item_t got;
        if (!rst_n)
        begin
            empty_node(0);
            free_slot = 1;
            expected_routes.delete();
            mismatches <= 0;
            outstanding <= 0;
            lookup_hits <= 0;
            dropped_inserts <= 0;
        end
        else
        begin
            // The response side is handled first, so that it is only ever matched
            // against requests that were accepted at an earlier edge.
            if (rsp_valid && rsp_ready)
            begin
                got = rsp;
                if (expected_routes.size() == 0)
                begin
                    $error("response transfer with no request outstanding: %h", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_routes[0];
                    expected_routes.delete(0);
                    if (got.found !== want.found)
                        $error("found: expected %0d, got %0d", want.found, got.found);
                    if (got.hop_out !== want.hop_out)
                        $error("hop_out: expected %h, got %h", want.hop_out, got.hop_out);
                    if (got.port_out !== want.port_out)
                        $error("port_out: expected %h, got %h", want.port_out, got.port_out);
                    if (got.pool_full !== want.pool_full)
                        $error("pool_full: expected %0d, got %0d", want.pool_full, got.pool_full);
                    mismatches <= mismatches + (got.found !== want.found)
                        + (got.hop_out !== want.hop_out) + (got.port_out !== want.port_out)
                        + (got.pool_full !== want.pool_full);
                    if (want.found)
                        lookup_hits <= lookup_hits + 1;
                    if (want.pool_full)
                        dropped_inserts <= dropped_inserts + 1;
                end
            end
            if (req_valid && req_ready)
                expected_routes.insert(expected_routes.size(), apply_route_op(req));
            outstanding <= expected_routes.size();
        end
    end

endmodule

### tb/tb_binary_trie_prefix_lookup.sv
`timescale 1ns / 100ps
// Testbench top for binary_trie_prefix_lookup: clock, reset, route requests,
// response back-pressure, a stall watchdog and the verdict.
// Depends on btpl_pkg, the block's RTL and lpm_route_checker.
module tb_binary_trie_prefix_lookup;
    import btpl_pkg::*;

    // Number of random request transfers, not counting the unused code.
    localparam int RANDOM_ITEMS = 400;
    // Cycles without any transfer before the run is declared hung. The slowest
    // item walks 32 levels, creates 32 nodes and then waits out a receiver stall.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet time after the last response, long enough for a stray result to show.
    localparam int DRAIN_CYCLES = 80;
    // The block answers this code with zeros and changes nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // How many stored prefixes are remembered to aim lookups at.
    localparam int PREFIX_MEMORY = 64;

    typedef struct {
        logic [ADDR_W-1:0] base;
        int                len;
    } prefix_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    int mismatches;
    int outstanding;
    int lookup_hits;
    int dropped_inserts;

    int         idle_cycles = 0;
    logic [9:0] stall_phase = '0;
    int         burst_left = 0;
    int         sent_by_op [4];
    prefix_t    known_prefixes [$];

    always #5 clk = ~clk;

    binary_trie_prefix_lookup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lpm_route_checker route_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .lookup_hits     (lookup_hits),
        .dropped_inserts (dropped_inserts)
    );

    // Mask with the given number of leading ones; a length of 32 gives all ones.
    function automatic logic [ADDR_W-1:0] lead_mask(int len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

    function automatic req_item_t make_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] address,
                                           logic [ADDR_W-1:0] prefix_mask,
                                           logic [HOP_W-1:0] hop_in,
                                           logic [PORT_W-1:0] port_in);
        req_item_t item;
        item.op = op;
        item.address = address;
        item.prefix_mask = prefix_mask;
        item.hop_in = hop_in;
        item.port_in = port_in;
        return item;
    endfunction

    // Presents one request and returns once it is transferred, or, when that
    // ends a burst, after a random gap with valid low. The sender works in bursts,
    // and valid is never lowered and raised in the same step, since back-to-back
    // items simply keep it high.
    task automatic push_request(input req_item_t item);
        int len;
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent_by_op[item.op]++;
        // Remember where routes were stored so that lookups can be aimed at them.
        if (item.op == OP_CLEAR)
            known_prefixes.delete();
        else if (item.op == OP_INSERT && known_prefixes.size() < PREFIX_MEMORY)
        begin
            len = 0;
            while (len < ADDR_W && item.prefix_mask[ADDR_W - 1 - len])
                len++;
            known_prefixes.insert(known_prefixes.size(), '{base: item.address, len: len});
        end
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 50))
                @(posedge clk);
            burst_left = $urandom_range(0, 16);
        end
        else
            burst_left--;
    endtask

    // The receiver cycles through four stall patterns: always ready, mostly
    // ready, ready one cycle in eight, and a fair coin. They take turns, so
    // stalls land on every stage of the trie walk.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= (stall_phase[2:0] == 3'd5);
            default: rsp_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timed out after %0d cycles with no transfer.", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                random_sent;
        int                epoch_len;
        int                len;
        int                pick;
        logic              flood;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        prefix_t           anchor;

        foreach (sent_by_op[i])
            sent_by_op[i] = 0;
        random_sent = 0;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty table misses, then the default route on its own
        // answers every address.
        push_request(make_req(OP_LOOKUP, 32'h0000_0000, '0, '0, '0));
        push_request(make_req(OP_INSERT, 32'h1234_5678, 32'h0000_0000, 32'hC0A8_0001, 8'hFF));
        push_request(make_req(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0));
        // Nested prefixes: the deepest one on the path wins.
        push_request(make_req(OP_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'h01));
        push_request(make_req(OP_INSERT, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 8'h02));
        push_request(make_req(OP_LOOKUP, 32'h0A01_0203, '0, '0, '0));
        push_request(make_req(OP_LOOKUP, 32'h0A02_0000, '0, '0, '0));
        // Full-length routes at both ends of the address space, one with all-zero
        // hop and port, which must still count as found.
        push_request(make_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        push_request(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        push_request(make_req(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00));
        push_request(make_req(OP_LOOKUP, 32'h0000_0000, '0, '0, '0));
        // Overwriting an existing route.
        push_request(make_req(OP_INSERT, 32'h0AFF_FFFF, 32'hFF00_0000, 32'h5555_AAAA, 8'h5A));
        push_request(make_req(OP_LOOKUP, 32'h0A09_0909, '0, '0, '0));
        // A broken mask only counts up to its first zero: this is a /4.
        push_request(make_req(OP_INSERT, 32'hC000_0000, 32'hF0F0_F0F0, 32'hAAAA_5555, 8'hA5));
        push_request(make_req(OP_LOOKUP, 32'hC123_4567, '0, '0, '0));
        // The unused code with every field set must change nothing.
        push_request(make_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        push_request(make_req(OP_LOOKUP, 32'hCFFF_FFFF, '0, '0, '0));
        // A clear removes everything, the default route included.
        push_request(make_req(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        push_request(make_req(OP_LOOKUP, 32'h0A01_0203, '0, '0, '0));
        push_request(make_req(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0));
        // Address bits beyond the prefix are ignored by an insert.
        push_request(make_req(OP_INSERT, 32'h8FFF_FFFF, 32'hF000_0000, 32'h0102_0304, 8'h80));
        push_request(make_req(OP_LOOKUP, 32'h8000_0001, '0, '0, '0));

        // Random part, in epochs. Most epochs start from an empty table; the others
        // pile onto what is there, and a flood epoch of long prefixes runs the node
        // pool dry so that dropped inserts and left-over path nodes get exercised.
        while (random_sent < RANDOM_ITEMS)
        begin
            epoch_len = $urandom_range(10, 60);
            flood = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                push_request(make_req(OP_CLEAR, $urandom, $urandom, $urandom,
                                      PORT_W'($urandom)));
                random_sent++;
            end
            for (int k = 0; k < epoch_len && random_sent < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < (flood ? 60 : 35))
                begin
                    // Insert: mostly typical lengths, sometimes the extremes, and
                    // often a longer prefix under one already stored.
                    pick = $urandom_range(0, 9);
                    if (flood || pick == 1)
                        len = ADDR_W;
                    else if (pick == 0)
                        len = 0;
                    else if (pick < 4)
                        len = $urandom_range(1, ADDR_W - 1);
                    else
                        len = $urandom_range(8, 24);
                    addr = $urandom;
                    if (known_prefixes.size() > 0 && $urandom_range(0, 1) == 1)
                    begin
                        anchor = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
                        if (len < anchor.len)
                            len = $urandom_range(anchor.len, ADDR_W);
                        addr = (anchor.base & lead_mask(anchor.len))
                             | (addr & ~lead_mask(anchor.len));
                    end
                    mask = lead_mask(len);
                    if ($urandom_range(0, 1) == 1)
                        mask = mask | ($urandom & ({ADDR_W{1'b1}} >> (len + 1)));
                    push_request(make_req(OP_INSERT, addr, mask, $urandom, PORT_W'($urandom)));
                    random_sent++;
                end
                else if (pick < 90)
                begin
                    // Lookup: usually inside a stored prefix, otherwise anywhere.
                    addr = $urandom;
                    if (known_prefixes.size() > 0 && $urandom_range(0, 9) < 7)
                    begin
                        anchor = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
                        addr = (anchor.base & lead_mask(anchor.len))
                             | (addr & ~lead_mask(anchor.len));
                    end
                    push_request(make_req(OP_LOOKUP, addr, $urandom, $urandom,
                                          PORT_W'($urandom)));
                    random_sent++;
                end
                else
                begin
                    // Noise: any code with every field random.
                    push_request(make_req(OP_W'($urandom_range(0, 3)), $urandom, $urandom,
                                          $urandom, PORT_W'($urandom)));
                    if (req.op != OP_UNUSED)
                        random_sent++;
                end
            end
        end

        // Let every response come home, then watch for anything unexpected.
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run covered %0d inserts, %0d lookups, %0d clears and %0d unused codes.",
                 sent_by_op[OP_INSERT], sent_by_op[OP_LOOKUP], sent_by_op[OP_CLEAR],
                 sent_by_op[OP_UNUSED]);
        $display("Lookups that hit a route: %0d; inserts dropped on a full node pool: %0d.",
                 lookup_hits, dropped_inserts);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
